FILE: src/rlrf_pkg.sv
// rlrf_pkg: shared types and codes for the run-length region feature block
// no dependencies; imported by every module under src

package rlrf_pkg;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MULC = 7'b0000010,
    S_ADDC = 7'b0000100,
    S_ADDR = 7'b0001000,
    S_DIVC = 7'b0010000,
    S_DIVR = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SKIPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef struct packed {
    logic clear;
    logic mul_span;
    logic mul_row;
    logic add_cmom;
    logic add_rest;
    logic set_skip;
  } acc_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/rlrf_divider.sv
// rlrf_divider: shared restoring divider, one quotient bit per cycle
// computes (numer << (QW-SHIFT)) / den, saturated to QW bits; uses rlrf_pkg

module rlrf_divider
  import rlrf_pkg::*;
#(
  parameter int NUM_W = 38,
  parameter int SHIFT = 12,
  parameter int QW    = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [NUM_W-1:0]         numer,
  input  logic [NUM_W-SHIFT-1:0]   den,
  output div_stat_t                stat,
  output logic [QW-1:0]            quot
);

  localparam int DEN_W = NUM_W - SHIFT;
  localparam int CNT_W = $clog2(QW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic [DEN_W-1:0]  hi;

  assign hi    = numer[NUM_W-1:SHIFT];
  assign trial = {rem_r, q_r[QW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      den_nxt = den;
      if (hi >= den) begin
        // quotient does not fit the field
        q_nxt    = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = hi;
        q_nxt    = QW'(numer[SHIFT-1:0]) << (QW - SHIFT);
        cnt_nxt  = CNT_W'(QW);
        busy_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

FILE: src/rlrf_accum.sv
// rlrf_accum: running sums, bounding box and the shared run multiplier
// driven by the sequencer in the top level through acc_cmd_t; uses rlrf_pkg

module rlrf_accum
  import rlrf_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  acc_cmd_t                  cmd,
  input  logic [COORD_BITS-1:0]     xs,
  input  logic [COORD_BITS-1:0]     xe,
  input  logic [COORD_BITS-1:0]     y,
  output logic [2*COORD_BITS:0]     area,
  output logic [COORD_BITS-1:0]     left_edge,
  output logic [COORD_BITS-1:0]     right_edge,
  output logic [COORD_BITS-1:0]     top_edge,
  output logic [COORD_BITS-1:0]     bottom_edge,
  output logic [3*COORD_BITS+1:0]   cmom,
  output logic [3*COORD_BITS:0]     rmom,
  output logic                      skipped
);

  localparam int CW  = COORD_BITS;
  localparam int AW  = 2 * CW + 1;
  localparam int CMW = 3 * CW + 2;
  localparam int RMW = 3 * CW + 1;
  localparam int PW  = 2 * CW + 2;

  logic [AW-1:0]  area_r, area_nxt;
  logic [CW-1:0]  left_r, left_nxt, right_r, right_nxt;
  logic [CW-1:0]  top_r, top_nxt, bottom_r, bottom_nxt;
  logic [CMW-1:0] cmom_r, cmom_nxt;
  logic [RMW-1:0] rmom_r, rmom_nxt;
  logic           skip_r, skip_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;

  logic [CW:0]    len;
  logic [CW:0]    span;
  logic [CW:0]    mul_b;
  logic [PW-1:0]  prod;
  logic [AW:0]    area_sum;
  logic [CMW:0]   cmom_sum;
  logic [RMW:0]   rmom_sum;

  assign len   = {1'b0, xe} - {1'b0, xs} + (CW+1)'(1);
  assign span  = {1'b0, xs} + {1'b0, xe};
  assign mul_b = cmd.mul_row ? {1'b0, y} : span;
  assign prod  = len * mul_b;

  assign area_sum = {1'b0, area_r} + (AW+1)'(len);
  assign cmom_sum = {1'b0, cmom_r} + (CMW+1)'(prod_r);
  assign rmom_sum = {1'b0, rmom_r} + (RMW+1)'(prod_r);

  always_comb begin
    area_nxt   = area_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    top_nxt    = top_r;
    bottom_nxt = bottom_r;
    cmom_nxt   = cmom_r;
    rmom_nxt   = rmom_r;
    skip_nxt   = skip_r;
    prod_nxt   = prod_r;
    if (cmd.mul_span || cmd.mul_row) begin
      prod_nxt = prod;
    end
    if (cmd.add_cmom) begin
      cmom_nxt = cmom_sum[CMW] ? '1 : cmom_sum[CMW-1:0];
    end
    if (cmd.add_rest) begin
      rmom_nxt = rmom_sum[RMW] ? '1 : rmom_sum[RMW-1:0];
      area_nxt = area_sum[AW] ? '1 : area_sum[AW-1:0];
      if (xs < left_r) left_nxt = xs;
      if (xe > right_r) right_nxt = xe;
      if (y < top_r) top_nxt = y;
      if (y > bottom_r) bottom_nxt = y;
    end
    if (cmd.set_skip) begin
      skip_nxt = 1'b1;
    end
    if (cmd.clear) begin
      area_nxt   = '0;
      left_nxt   = '1;
      right_nxt  = '0;
      top_nxt    = '1;
      bottom_nxt = '0;
      cmom_nxt   = '0;
      rmom_nxt   = '0;
      skip_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r   <= '0;
      left_r   <= '1;
      right_r  <= '0;
      top_r    <= '1;
      bottom_r <= '0;
      cmom_r   <= '0;
      rmom_r   <= '0;
      skip_r   <= 1'b0;
    end else begin
      area_r   <= area_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
      cmom_r   <= cmom_nxt;
      rmom_r   <= rmom_nxt;
      skip_r   <= skip_nxt;
    end
    prod_r <= prod_nxt;
  end

  assign area        = area_r;
  assign left_edge   = left_r;
  assign right_edge  = right_r;
  assign top_edge    = top_r;
  assign bottom_edge = bottom_r;
  assign cmom        = cmom_r;
  assign rmom        = rmom_r;
  assign skipped     = skip_r;

endmodule

FILE: src/run_length_region_features.sv
// Region features from run-length code. Each input transfer is one horizontal run
// (start column, end column, row, last-run mark, tag). For a valid run the sequencer
// steps the shared run multiplier twice and adds into the saturating sums before it
// takes the next transfer. A reversed run (end before start) adds nothing and marks
// the object skipped. On the last run the shared divider produces both centroids one
// quotient bit per cycle; an empty object skips the divider. The result sits in an
// output register; the next run is taken while it waits, and an object that finishes
// while the previous result is still untaken waits for it to leave.
// Depends on rlrf_pkg, rlrf_accum and rlrf_divider.

module run_length_region_features
  import rlrf_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8,
  parameter int TAG_BITS   = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [COORD_BITS-1:0]              in_x_start,
  input  logic [COORD_BITS-1:0]              in_x_end,
  input  logic [COORD_BITS-1:0]              in_row,
  input  logic                               in_last_run,
  input  logic [TAG_BITS-1:0]                in_object_tag,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [TAG_BITS-1:0]                out_tag_out,
  output logic [2*COORD_BITS:0]              out_area,
  output logic [COORD_BITS-1:0]              out_min_col,
  output logic [COORD_BITS-1:0]              out_max_col,
  output logic [COORD_BITS-1:0]              out_min_row,
  output logic [COORD_BITS-1:0]              out_max_row,
  output logic [COORD_BITS+FRAC_BITS-1:0]    out_centroid_col,
  output logic [COORD_BITS+FRAC_BITS-1:0]    out_centroid_row,
  output logic [1:0]                         out_status
);

  localparam int CW  = COORD_BITS;
  localparam int AW  = 2 * CW + 1;
  localparam int CMW = 3 * CW + 2;
  localparam int RMW = 3 * CW + 1;
  localparam int DW  = 2 * CW + 2;
  localparam int QW  = CW + FRAC_BITS;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       xs_r, xe_r, y_r;
  logic                last_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [QW-1:0]       ccol_r, ccol_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [TAG_BITS-1:0] o_tag_r;
  logic [AW-1:0]       o_area_r;
  logic [CW-1:0]       o_minc_r, o_maxc_r, o_minr_r, o_maxr_r;
  logic [QW-1:0]       o_ccol_r, o_crow_r;
  logic [1:0]          o_status_r;
  logic                out_load;

  acc_cmd_t            cmd;
  div_stat_t           dstat;
  logic                div_start;
  logic                div_row;
  logic [CMW-1:0]      div_numer;
  logic [DW-1:0]       div_den;
  logic [QW-1:0]       quot;

  logic [AW-1:0]       area;
  logic [CW-1:0]       left_edge, right_edge, top_edge, bottom_edge;
  logic [CMW-1:0]      cmom;
  logic [RMW-1:0]      rmom;
  logic                skipped;
  logic                in_xfer;
  logic                empty;

  assign in_xfer = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign empty = (area == '0);

  rlrf_accum #(
    .COORD_BITS(COORD_BITS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .xs         (xs_r),
    .xe         (xe_r),
    .y          (y_r),
    .area       (area),
    .left_edge  (left_edge),
    .right_edge (right_edge),
    .top_edge   (top_edge),
    .bottom_edge(bottom_edge),
    .cmom       (cmom),
    .rmom       (rmom),
    .skipped    (skipped)
  );

  assign div_numer = div_row ? CMW'(rmom) : cmom;
  assign div_den   = div_row ? DW'(area) : {area, 1'b0};

  rlrf_divider #(
    .NUM_W(CMW),
    .SHIFT(CW),
    .QW   (QW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .numer(div_numer),
    .den  (div_den),
    .stat (dstat),
    .quot (quot)
  );

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    div_start = 1'b0;
    div_row   = 1'b0;
    ccol_nxt  = ccol_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_MULC;
      end
      S_MULC: begin
        if (xe_r < xs_r) begin
          cmd.set_skip = 1'b1;
          state_nxt = last_r ? S_ADDR : S_IDLE;
        end else begin
          cmd.mul_span = 1'b1;
          state_nxt = S_ADDC;
        end
      end
      S_ADDC: begin
        cmd.add_cmom = 1'b1;
        cmd.mul_row  = 1'b1;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        // a reversed last run arrives here with nothing to add
        cmd.add_rest = !(xe_r < xs_r);
        state_nxt = last_r ? S_DIVC : S_IDLE;
      end
      S_DIVC: begin
        if (empty) begin
          state_nxt = S_OUT;
        end else if (!dstat.busy && !dstat.done) begin
          div_start = 1'b1;
        end else if (dstat.done) begin
          ccol_nxt  = quot;
          div_row   = 1'b1;
          div_start = 1'b1;
          state_nxt = S_DIVR;
        end
      end
      S_DIVR: begin
        div_row = 1'b1;
        if (dstat.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_xfer) begin
      xs_r   <= in_x_start;
      xe_r   <= in_x_end;
      y_r    <= in_row;
      last_r <= in_last_run;
      tag_r  <= in_object_tag;
    end
    ccol_r <= ccol_nxt;
    if (out_load) begin
      o_tag_r <= tag_r;
      if (empty) begin
        o_area_r   <= '0;
        o_minc_r   <= '0;
        o_maxc_r   <= '0;
        o_minr_r   <= '0;
        o_maxr_r   <= '0;
        o_ccol_r   <= '0;
        o_crow_r   <= '0;
        o_status_r <= ST_EMPTY;
      end else begin
        o_area_r   <= area;
        o_minc_r   <= left_edge;
        o_maxc_r   <= right_edge;
        o_minr_r   <= top_edge;
        o_maxr_r   <= bottom_edge;
        o_ccol_r   <= ccol_r;
        o_crow_r   <= quot;
        o_status_r <= skipped ? ST_SKIPPED : ST_OK;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tag_out      = o_tag_r;
  assign out_area         = o_area_r;
  assign out_min_col      = o_minc_r;
  assign out_max_col      = o_maxc_r;
  assign out_min_row      = o_minr_r;
  assign out_max_row      = o_maxr_r;
  assign out_centroid_col = o_ccol_r;
  assign out_centroid_row = o_crow_r;
  assign out_status       = o_status_r;

endmodule

FILE: src/rlrf_checker.sv
// rlrf_checker: port-level assertions for run_length_region_features
// bound to the top level below; uses rlrf_pkg status codes

module rlrf_checker
  import rlrf_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2*COORD_BITS:0]           out_area,
  input logic [COORD_BITS-1:0]           out_min_col,
  input logic [COORD_BITS-1:0]           out_max_col,
  input logic [COORD_BITS-1:0]           out_min_row,
  input logic [COORD_BITS-1:0]           out_max_row,
  input logic [COORD_BITS+FRAC_BITS-1:0] out_centroid_col,
  input logic [COORD_BITS+FRAC_BITS-1:0] out_centroid_row,
  input logic [1:0]                      out_status
);

  // area, status and centroids held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_area) && $stable(out_status)
      && $stable(out_centroid_col) && $stable(out_centroid_row))
    else $error("result changed while stalled");

  // after a run transfer the sequencer is busy and in_ready is low
  a_busy_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a run transfer");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_area == '0 && out_centroid_col == '0
      && out_centroid_row == '0 && out_max_col == '0 && out_max_row == '0)
    else $error("empty object with nonzero fields");

  // nonempty objects have nonzero area, an ordered bounding box and status ok or skipped
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_EMPTY |-> out_area != '0
      && out_min_col <= out_max_col && out_min_row <= out_max_row
      && (out_status == ST_OK || out_status == ST_SKIPPED))
    else $error("bad bounding box or status");

endmodule

bind run_length_region_features rlrf_checker #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_rlrf_checker (.*);

FILE: test/region_feature_checker.sv
`timescale 1ns / 100ps
// region_feature_checker: watches the run and result channels of the region feature block,
// predicts the feature record of every object and compares it with each result transfer
// depends on rlrf_pkg for the status codes

module region_feature_checker
  import rlrf_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8,
  parameter int TAG_BITS   = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [COORD_BITS-1:0]           in_x_start,
  input  logic [COORD_BITS-1:0]           in_x_end,
  input  logic [COORD_BITS-1:0]           in_row,
  input  logic                            in_last_run,
  input  logic [TAG_BITS-1:0]             in_object_tag,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [TAG_BITS-1:0]             out_tag_out,
  input  logic [2*COORD_BITS:0]           out_area,
  input  logic [COORD_BITS-1:0]           out_min_col,
  input  logic [COORD_BITS-1:0]           out_max_col,
  input  logic [COORD_BITS-1:0]           out_min_row,
  input  logic [COORD_BITS-1:0]           out_max_row,
  input  logic [COORD_BITS+FRAC_BITS-1:0] out_centroid_col,
  input  logic [COORD_BITS+FRAC_BITS-1:0] out_centroid_row,
  input  logic [1:0]                      out_status,
  output int                              fail_count,
  output int                              pending
);

  localparam int AREA_W = 2 * COORD_BITS + 1;
  localparam int CMOM_W = 3 * COORD_BITS + 2;
  localparam int RMOM_W = 3 * COORD_BITS + 1;
  localparam int CENT_W = COORD_BITS + FRAC_BITS;
  localparam logic [63:0] COORD_MAX = (64'd1 << COORD_BITS) - 64'd1;
  localparam logic [63:0] AREA_MAX  = (64'd1 << AREA_W) - 64'd1;
  localparam logic [63:0] CMOM_MAX  = (64'd1 << CMOM_W) - 64'd1;
  localparam logic [63:0] RMOM_MAX  = (64'd1 << RMOM_W) - 64'd1;
  localparam logic [63:0] CENT_MAX  = (64'd1 << CENT_W) - 64'd1;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [AREA_W-1:0]     area;
    logic [COORD_BITS-1:0] min_col;
    logic [COORD_BITS-1:0] max_col;
    logic [COORD_BITS-1:0] min_row;
    logic [COORD_BITS-1:0] max_row;
    logic [CENT_W-1:0]     centroid_col;
    logic [CENT_W-1:0]     centroid_row;
    logic [1:0]            status;
  } region_record_t;

  region_record_t expected_records[$];
  region_record_t want_rec;

  logic [63:0] pixel_count;
  logic [63:0] left_col;
  logic [63:0] right_col;
  logic [63:0] top_row;
  logic [63:0] bottom_row;
  logic [63:0] col_moment2;
  logic [63:0] row_moment_sum;
  logic        run_skipped;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [63:0] sat_sum(logic [63:0] acc, logic [63:0] add,
                                          logic [63:0] limit);
    if (add >= limit || acc > limit - add) return limit;
    return acc + add;
  endfunction

  function automatic logic [63:0] fixed_mean(logic [63:0] moment, logic [63:0] divisor);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = moment / divisor;
    rem = moment % divisor;
    if (quo > COORD_MAX) return CENT_MAX;
    return (quo << FRAC_BITS) + ((rem << FRAC_BITS) / divisor);
  endfunction

  task automatic clear_object();
    pixel_count = '0;
    left_col = COORD_MAX;
    right_col = '0;
    top_row = COORD_MAX;
    bottom_row = '0;
    col_moment2 = '0;
    row_moment_sum = '0;
    run_skipped = 1'b0;
  endtask

  task automatic absorb_run(input logic [COORD_BITS-1:0] xs, input logic [COORD_BITS-1:0] xe,
                            input logic [COORD_BITS-1:0] y, input logic last,
                            input logic [TAG_BITS-1:0] tag);
    logic [63:0] span;
    region_record_t rec;
    if (xe < xs) begin
      run_skipped = 1'b1;
    end else begin
      span = 64'(xe) - 64'(xs) + 64'd1;
      pixel_count = sat_sum(pixel_count, span, AREA_MAX);
      col_moment2 = sat_sum(col_moment2, (64'(xs) + 64'(xe)) * span, CMOM_MAX);
      row_moment_sum = sat_sum(row_moment_sum, 64'(y) * span, RMOM_MAX);
      if (64'(xs) < left_col) left_col = 64'(xs);
      if (64'(xe) > right_col) right_col = 64'(xe);
      if (64'(y) < top_row) top_row = 64'(y);
      if (64'(y) > bottom_row) bottom_row = 64'(y);
    end
    if (last) begin
      rec = '0;
      rec.tag = tag;
      if (pixel_count == 0) begin
        rec.status = ST_EMPTY;
      end else begin
        rec.area = pixel_count[AREA_W-1:0];
        rec.min_col = left_col[COORD_BITS-1:0];
        rec.max_col = right_col[COORD_BITS-1:0];
        rec.min_row = top_row[COORD_BITS-1:0];
        rec.max_row = bottom_row[COORD_BITS-1:0];
        rec.centroid_col = CENT_W'(fixed_mean(col_moment2, 64'd2 * pixel_count));
        rec.centroid_row = CENT_W'(fixed_mean(row_moment_sum, pixel_count));
        rec.status = run_skipped ? ST_SKIPPED : ST_OK;
      end
      expected_records.push_back(rec);
      clear_object();
    end
  endtask

  task automatic report_failure(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got)
      report_failure($sformatf("tag %0d %s expected %0d got %0d",
                               want_rec.tag, field, want, got));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_object();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          report_failure($sformatf("result transfer with tag %0d and none expected",
                                   out_tag_out));
        end else begin
          want_rec = expected_records.pop_front();
          compare_field("tag", 64'(want_rec.tag), 64'(out_tag_out));
          compare_field("area", 64'(want_rec.area), 64'(out_area));
          compare_field("min_col", 64'(want_rec.min_col), 64'(out_min_col));
          compare_field("max_col", 64'(want_rec.max_col), 64'(out_max_col));
          compare_field("min_row", 64'(want_rec.min_row), 64'(out_min_row));
          compare_field("max_row", 64'(want_rec.max_row), 64'(out_max_row));
          compare_field("centroid_col", 64'(want_rec.centroid_col), 64'(out_centroid_col));
          compare_field("centroid_row", 64'(want_rec.centroid_row), 64'(out_centroid_row));
          compare_field("status", 64'(want_rec.status), 64'(out_status));
        end
      end
      if (in_valid && in_ready)
        absorb_run(in_x_start, in_x_end, in_row, in_last_run, in_object_tag);
    end
    pending <= expected_records.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// testbench: drives run transfers into run_length_region_features under several idle and
// stall patterns and gives the verdict; region_feature_checker does the prediction

module testbench;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int TAG_BITS   = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 380;
  localparam int HOLD_CYCLES = 600;
  localparam int BIG_RUNS = 200;
  localparam logic [COORD_BITS-1:0] CMAX = {COORD_BITS{1'b1}};

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [COORD_BITS-1:0]           in_x_start = '0;
  logic [COORD_BITS-1:0]           in_x_end = '0;
  logic [COORD_BITS-1:0]           in_row = '0;
  logic                            in_last_run = 1'b0;
  logic [TAG_BITS-1:0]             in_object_tag = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [TAG_BITS-1:0]             out_tag_out;
  logic [2*COORD_BITS:0]           out_area;
  logic [COORD_BITS-1:0]           out_min_col;
  logic [COORD_BITS-1:0]           out_max_col;
  logic [COORD_BITS-1:0]           out_min_row;
  logic [COORD_BITS-1:0]           out_max_row;
  logic [COORD_BITS+FRAC_BITS-1:0] out_centroid_col;
  logic [COORD_BITS+FRAC_BITS-1:0] out_centroid_row;
  logic [1:0]                      out_status;
  int                              fail_count;
  int                              pending;

  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_epoch = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int items_sent = 0;

  run_length_region_features DUT (.*);
  region_feature_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_epoch != hold_seen) begin
      hold_seen <= hold_epoch;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_run(input logic [COORD_BITS-1:0] xs, input logic [COORD_BITS-1:0] xe,
                          input logic [COORD_BITS-1:0] y, input logic last,
                          input logic [TAG_BITS-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_start <= xs;
    in_x_end <= xe;
    in_row <= y;
    in_last_run <= last;
    in_object_tag <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3: return COORD_BITS'($urandom_range(63));
      4, 5:       return CMAX - COORD_BITS'($urandom_range(63));
      default:    return COORD_BITS'($urandom_range(int'(CMAX)));
    endcase
  endfunction

  task automatic send_object(input int runs, input int reverse_pct);
    logic [COORD_BITS-1:0] xs;
    logic [COORD_BITS-1:0] xe;
    logic [COORD_BITS-1:0] y;
    logic [TAG_BITS-1:0]   tag;
    int span;
    int stop;
    tag = TAG_BITS'($urandom_range(255));
    y = rand_coord();
    for (int k = 0; k < runs; k++) begin
      xs = rand_coord();
      if ($urandom_range(99) < reverse_pct && xs != 0) begin
        xe = COORD_BITS'($urandom_range(int'(xs) - 1));
      end else begin
        case ($urandom_range(9))
          0:       span = $urandom_range(int'(CMAX));
          1, 2:    span = $urandom_range(255);
          default: span = $urandom_range(15);
        endcase
        stop = int'(xs) + span;
        xe = (stop > int'(CMAX)) ? CMAX : COORD_BITS'(stop);
      end
      send_run(xs, xe, y, k == runs - 1, tag);
      if (y < CMAX && $urandom_range(4) != 0) y = y + 1'b1;
      else y = rand_coord();
    end
  endtask

  task automatic random_objects(input int target);
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 78)      send_object($urandom_range(8, 1), 8);
      else if (pick < 86) send_object($urandom_range(3, 1), 100);
      else if (pick < 95) send_object(1, 0);
      else                send_object($urandom_range(40, 10), 20);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // directed corners
    send_run('0, '0, '0, 1'b1, 8'h00);
    send_run('0, CMAX, CMAX, 1'b1, 8'hFF);
    send_run(CMAX, '0, 12'd100, 1'b1, 8'hAA);
    send_run(CMAX, '0, 12'd5, 1'b0, 8'h11);
    send_run(12'd10, 12'd20, 12'd7, 1'b0, 8'h11);
    send_run(12'd100, 12'd100, CMAX, 1'b1, 8'h55);
    send_run(CMAX, CMAX, CMAX, 1'b1, 8'h0F);
    send_run(12'd1, 12'd0, 12'd0, 1'b0, 8'h22);
    send_run(12'd2048, 12'd2047, 12'd3000, 1'b1, 8'hF0);
    send_run(12'd5, 12'd9, 12'd0, 1'b0, 8'h3C);
    send_run('0, CMAX, 12'd2, 1'b0, 8'h3C);
    send_run(12'd7, 12'd7, 12'd1, 1'b1, 8'h3C);
    send_run(12'd2047, 12'd2048, 12'd2048, 1'b1, 8'hC3);
    send_run(12'd1365, 12'd2730, 12'd2730, 1'b0, 8'h5A);
    send_run(12'd2730, 12'd1365, 12'd1365, 1'b1, 8'hA5);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 86; end
        default: begin send_idle_pct = 37; recv_stall_pct <= 37; end
      endcase
      if (phase == 0) hold_epoch <= hold_epoch + 1;
      random_objects(items_sent + PHASE_ITEMS);
      wait_drained();
    end

    // one long object of full-width runs
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    for (int k = 0; k < BIG_RUNS; k++)
      send_run('0, CMAX, COORD_BITS'(k), k == BIG_RUNS - 1, 8'h99);
    wait_drained();

    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rlrf_pkg.sv
src/rlrf_divider.sv
src/rlrf_accum.sv
src/run_length_region_features.sv
src/rlrf_checker.sv
test/region_feature_checker.sv
test/testbench.sv
